// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the median filter files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define RMF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RMF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/rmf_pkg.sv =====
package rmf_pkg;

    localparam int SAMPLE_W   = 10;
    localparam int TDATA_W    = 16;
    localparam int WINDOW_DEF = 100;

    typedef logic [SAMPLE_W-1:0] t_sample;

endpackage

// ===== sv/running_median_filter.sv =====
// Running median filter over the last WINDOW converter samples.
// Input: slave stream, one 10-bit sample per word in i_s_tdata[9:0].
// Output: master stream, one 10-bit median per input word in o_m_tdata[9:0];
// even windows give the floor of the mean of the two middle values.
// Each accepted sample is inserted into a chain of WINDOW sorted cells while
// the sample that entered WINDOW words earlier is dropped; every cell updates
// from its two neighbors in the same cycle. A history line inside the cells
// supplies the sample to drop.
// A taken sample updates the cells and sets r_pend; its median then loads into the output register behind o_m_tvalid.
// Throughput: one word per cycle while the receiver does not stall the output.
// Reset zeroes the window and the history, so early medians count zeros.
// When the receiver stalls, one result waits in the output register and one
// in the cell chain; o_s_tready drops only when both are occupied.
`include "assert_macros.svh"

module running_median_filter
    import rmf_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [TDATA_W-1:0] i_s_tdata,   // [9:0] sample
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [TDATA_W-1:0] o_m_tdata    // [9:0] median
);

    localparam int LO_IDX = (WINDOW - 1) / 2;
    localparam int HI_IDX = WINDOW / 2;

    t_sample cell_val  [WINDOW];
    t_sample cell_hist [WINDOW];

    t_sample new_s;
    logic    accept;
    logic    out_free;
    logic    r_pend;
    logic    n_pend;

    assign new_s      = i_s_tdata[SAMPLE_W-1:0];
    assign o_s_tready = !r_pend || out_free;
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        if (accept) begin
            n_pend = 1'b1;
        end else if (out_free) begin
            n_pend = 1'b0;
        end else begin
            n_pend = r_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= n_pend;
        end
    end

    for (genvar i = 0; i < WINDOW; i++) begin : g_cell
        t_sample prev_v;
        t_sample next_v;
        t_sample hist_in;

        if (i == 0) begin : g_first
            assign prev_v  = '0;
            assign hist_in = new_s;
        end else begin : g_mid
            assign prev_v  = cell_val[i-1];
            assign hist_in = cell_hist[i-1];
        end

        if (i == WINDOW - 1) begin : g_last
            assign next_v = '0;
        end else begin : g_inner
            assign next_v = cell_val[i+1];
        end

        rmf_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_shift    (accept),
            .i_new      (new_s),
            .i_old      (cell_hist[WINDOW-1]),
            .i_prev     (prev_v),
            .i_has_prev (i != 0),
            .i_next     (next_v),
            .i_has_next (i != WINDOW - 1),
            .i_hist     (hist_in),
            .o_val      (cell_val[i]),
            .o_hist     (cell_hist[i])
        );
    end

    rmf_median_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (r_pend && out_free),
        .i_lo       (cell_val[LO_IDX]),
        .i_hi       (cell_val[HI_IDX]),
        .o_free     (out_free),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    for (genvar i = 0; i < WINDOW - 1; i++) begin : g_chk
        `RMF_ASSERT(a_sorted, i_clk, i_rst_n, cell_val[i] <= cell_val[i+1], "window out of order")
    end

    `RMF_ASSERT_NEXT(a_take_pend, i_clk, i_rst_n, accept, r_pend, "accepted sample not pending")
    `RMF_ASSERT_NEXT(a_hold_pend, i_clk, i_rst_n, r_pend && !out_free, r_pend, "pending median lost")

endmodule

// ===== sv/rmf_cell.sv =====
// One slot of the sorted window plus one stage of the sample history line.
module rmf_cell
    import rmf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_shift,
    input  t_sample i_new,
    input  t_sample i_old,
    input  t_sample i_prev,
    input  logic    i_has_prev,
    input  t_sample i_next,
    input  logic    i_has_next,
    input  t_sample i_hist,
    output t_sample o_val,
    output t_sample o_hist
);

    t_sample r_val;
    t_sample r_hist;
    t_sample n_val;

    t_sample rem_here;
    logic    rem_here_vld;
    t_sample rem_prev;

    // Sorted list after dropping the first entry equal to the oldest sample:
    // entries below the dropped one stay, those above slide down by one.
    always_comb begin
        if (r_val < i_old) begin
            rem_here     = r_val;
            rem_here_vld = 1'b1;
        end else begin
            rem_here     = i_next;
            rem_here_vld = i_has_next;
        end
        rem_prev = (i_prev < i_old) ? i_prev : r_val;

        // Insert the new sample: keep smaller entries, push larger ones up.
        if (rem_here_vld && (rem_here <= i_new)) begin
            n_val = rem_here;
        end else if (i_has_prev && (rem_prev > i_new)) begin
            n_val = rem_prev;
        end else begin
            n_val = i_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val  <= '0;
            r_hist <= '0;
        end else if (i_shift) begin
            r_val  <= n_val;
            r_hist <= i_hist;
        end
    end

    assign o_val  = r_val;
    assign o_hist = r_hist;

endmodule

// ===== sv/rmf_median_out.sv =====
`include "assert_macros.svh"

// Average of the two middle slots and the output register.
module rmf_median_out
    import rmf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  t_sample            i_lo,
    input  t_sample            i_hi,
    output logic               o_free,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [TDATA_W-1:0] o_m_tdata    // [9:0] median
);

    logic                r_out_vld;
    t_sample             r_median;
    logic [SAMPLE_W:0]   sum;
    logic                out_stall;

    // Odd windows pass the same slot twice, so the mean is that slot.
    assign sum = {1'b0, i_lo} + {1'b0, i_hi};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_load) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_median <= sum[SAMPLE_W:1];
        end
    end

    assign o_free     = !r_out_vld || i_m_tready;
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {{(TDATA_W-SAMPLE_W){1'b0}}, r_median};
    assign out_stall  = r_out_vld && !i_m_tready;

    `RMF_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, i_load, r_out_vld, "loaded median not valid")
    `RMF_ASSERT_NEXT(a_hold_vld, i_clk, i_rst_n, out_stall, r_out_vld, "median dropped")
    `RMF_ASSERT_NEXT(a_hold_data, i_clk, i_rst_n, out_stall, $stable(r_median), "median changed")

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rmf_pkg::*;

    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          FLUSH_CYCLES = 8;
    localparam int          PHASE_ITEMS  = 210;
    localparam int          DIRECTED_LEN = 16;

    typedef enum int {
        MIX_UNIFORM,
        MIX_FLOOR,
        MIX_CEILING,
        MIX_BAND,
        MIX_PAIR
    } t_mix;

    typedef struct packed {
        t_sample sample;
        logic    typed;
        t_sample median;
    } t_row;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_s_tvalid = 1'b0;
    logic               o_s_tready;
    logic [TDATA_W-1:0] i_s_tdata  = '0;   // [9:0] sample
    logic               o_m_tvalid;
    logic               i_m_tready = 1'b0;
    logic [TDATA_W-1:0] o_m_tdata;         // [9:0] median

    int unsigned idle_pct    = 0;
    int unsigned stall_pct   = 0;
    bit          hold_active = 1'b0;
    event        hold_ev;
    int unsigned errors      = 0;
    int unsigned cycle_count = 0;

    t_sample     history [WINDOW_DEF];
    int unsigned next_slot = 0;
    t_sample     expected_medians [$];

    // The window starts all zero, so with fewer than half its slots filled
    // by nonzero words the median stays at zero.
    t_row directed [DIRECTED_LEN] = '{
        '{10'd0,    1'b1, 10'd0},
        '{10'd1023, 1'b1, 10'd0},
        '{10'd1,    1'b1, 10'd0},
        '{10'd2,    1'b1, 10'd0},
        '{10'd4,    1'b1, 10'd0},
        '{10'd8,    1'b1, 10'd0},
        '{10'd16,   1'b1, 10'd0},
        '{10'd32,   1'b1, 10'd0},
        '{10'd64,   1'b1, 10'd0},
        '{10'd128,  1'b1, 10'd0},
        '{10'd256,  1'b1, 10'd0},
        '{10'd512,  1'b1, 10'd0},
        '{10'h155,  1'b1, 10'd0},
        '{10'h2AA,  1'b1, 10'd0},
        '{10'd1022, 1'b1, 10'd0},
        '{10'd1023, 1'b1, 10'd0}
    };

    running_median_filter DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_m_tready <= !hold_active && ($urandom_range(99) >= stall_pct);
    end

    initial forever begin
        @(hold_ev);
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_active = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        errors++;
        $display("[%0t] median check: %s", $time, what);
    endtask

    // Overwrite the oldest slot, then sort a copy of the window.
    function automatic t_sample push_sample_median(input t_sample s);
        t_sample           sorted [WINDOW_DEF];
        t_sample           v;
        logic [SAMPLE_W:0] pair_sum;
        int                j;
        history[next_slot] = s;
        next_slot = (next_slot + 1) % WINDOW_DEF;
        for (int i = 0; i < WINDOW_DEF; i++) begin
            v = history[i];
            j = i;
            while (j > 0 && sorted[j-1] > v) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = v;
        end
        if (WINDOW_DEF % 2 == 1) begin
            return sorted[(WINDOW_DEF-1)/2];
        end
        // add at one extra bit, then halve rounding down
        pair_sum = sorted[WINDOW_DEF/2] + sorted[WINDOW_DEF/2-1];
        return pair_sum[SAMPLE_W:1];
    endfunction

    always @(posedge i_clk) begin
        t_sample want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_medians.size() == 0) begin
                report_mismatch($sformatf("median 0x%0h with none expected", o_m_tdata));
            end else begin
                want = expected_medians.pop_front();
                if (o_m_tdata !== TDATA_W'(want)) begin
                    report_mismatch($sformatf("got 0x%0h, want 0x%0h", o_m_tdata, want));
                end
            end
        end
    end

    task automatic send_sample(input t_sample s, input bit typed = 1'b0,
                               input t_sample typed_median = '0);
        t_sample want;
        while ($urandom_range(99) < idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= TDATA_W'(s);
        do @(posedge i_clk); while (!o_s_tready);
        want = push_sample_median(s);
        expected_medians.push_back(typed ? typed_median : want);
    endtask

    task automatic wait_for_medians();
        i_s_tvalid <= 1'b0;
        while (expected_medians.size() != 0) @(posedge i_clk);
    endtask

    // Segments of one flavor each, long enough to swing the median.
    task automatic send_random(input int unsigned count);
        t_mix        mix = MIX_UNIFORM;
        t_sample     lo_val = '0;
        t_sample     hi_val = '0;
        t_sample     s;
        int unsigned seg_left = 0;
        int          center = 0;
        int          t;
        repeat (count) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(160, 20);
                mix      = t_mix'($urandom_range(4));
                center   = int'($urandom_range(1023));
                lo_val   = t_sample'($urandom_range(1023));
                hi_val   = t_sample'($urandom_range(1023));
            end
            seg_left--;
            case (mix)
                MIX_FLOOR: begin
                    s = t_sample'($urandom_range(1));
                end
                MIX_CEILING: begin
                    s = t_sample'($urandom_range(1023, 1022));
                end
                MIX_BAND: begin
                    t = center + int'($urandom_range(16)) - 8;
                    if (t < 0) t = 0;
                    if (t > 1023) t = 1023;
                    s = t_sample'(t);
                end
                MIX_PAIR: begin
                    s = $urandom_range(1) ? hi_val : lo_val;
                end
                default: begin
                    s = t_sample'($urandom_range(1023));
                end
            endcase
            send_sample(s);
        end
    endtask

    initial begin
        foreach (history[i]) history[i] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) begin
            send_sample(directed[i].sample, directed[i].typed, directed[i].median);
        end

        send_random(PHASE_ITEMS);
        wait_for_medians();

        idle_pct  = 52;
        stall_pct = 0;
        send_random(PHASE_ITEMS);
        wait_for_medians();

        idle_pct  = 0;
        stall_pct = 52;
        send_random(PHASE_ITEMS);
        wait_for_medians();

        idle_pct  = 14;
        stall_pct = 14;
        send_random(PHASE_ITEMS);
        wait_for_medians();

        // hold the output off while words keep coming, so the input backs up
        idle_pct  = 0;
        stall_pct = 0;
        -> hold_ev;
        send_random(PHASE_ITEMS);
        wait_for_medians();

        repeat (FLUSH_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
